>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers of the UTF-8 stream decoder
// Clocked implication checks that are held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("u8d assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("u8d assertion failed");

`endif

>>> src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Result and queue entry types, byte class masks and register indexes.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW = 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgStripBom = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWideCp   = 1'd1;

  localparam logic [CpW-1:0] QMark = 21'h00003F;
  localparam logic [CpW-1:0] BomCp = 21'h00FEFF;

  // Byte class masks and patterns.
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           bad;
  } u8d_res_t;

  // One queue entry carries every result of one input byte.
  typedef struct packed {
    u8d_res_t res0;
    u8d_res_t res1;
    logic     two;
  } u8d_entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } u8d_q_status_t;

endpackage

>>> src/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_if: channel interfaces of the UTF-8 stream decoder
// Byte input channel and code point output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        malformed;
  logic        end_of_run;

  modport source (output valid, output code_point, output malformed,
                  output end_of_run, input ready);
  modport sink   (input valid, input code_point, input malformed,
                  input end_of_run, output ready);
endinterface

>>> src/utf8_stream_decoder_core.sv
// Path: each result passes through the queue and then the output register.
// Throughput: one byte per cycle unless the queue is full; a two-result byte
// holds the single output register for both; the four-entry queue absorbs the burst.
// Reset: open sequence cleared, at buffer start, both registers set to 1,
// queue and output register empty.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: streaming UTF-8 to code point decoder
// Front tracks sequences per byte; back serializes results behind a queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder_core import u8d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  u8d_in_if.sink             in_i,
  u8d_out_if.source          out_o
);

  // The front part does all the decoding work in the accepting cycle: it
  // classifies the byte, updates the open sequence and forms every result
  // that the byte causes (at most two) into a single queue entry. Bytes with
  // no result, such as stray continuation bytes, push nothing.
  logic          push, pop;
  u8d_entry_t    entry, head;
  u8d_q_status_t q_stat;

  u8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .entry_o     (entry)
  );

  // The queue decouples the two sides, so input keeps flowing, until the queue
  // fills, while the output side is stalled or busy with a two-result byte.
  u8d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_stat)
  );

  // The back part hands out one result per transaction and raises
  // end_of_run on the last result of each byte.
  u8d_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // A push never lands on a full queue, and an empty queue is never popped.
  `U8D_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push, !q_stat.full)
  `U8D_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop, !q_stat.empty)
  // The second result of a byte follows its first without a gap.
  `U8D_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni,
                   out_o.valid && out_o.ready && !out_o.end_of_run, out_o.valid)
  // The full flag agrees with the fill count.
  `U8D_ASSERT_IMPL(a_full_count, clk_i, rst_ni, q_stat.full,
                   q_stat.count == QCntW'(QDepth))

endmodule

>>> src/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and sequence tracker
// Accepts bytes, updates the open sequence and pushes the byte's results.
// ----------------------------------------------------------------------------
module u8d_front import u8d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  u8d_in_if.sink             in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output u8d_entry_t         entry_o
);

  logic           strip_bom_q, wide_q;
  logic [1:0]     aw_q, aw_d;
  logic [CpW-1:0] pv_q, pv_d;
  logic           fb_q, fb_d;
  logic           abs_q, abs_d;
  logic           accept;
  logic [1:0]     cnt;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0] b;
    logic       stray;
    u8d_res_t   r;
    b       = in_i.byte_in;
    stray   = 1'b0;
    cnt     = 2'd0;
    aw_d    = aw_q;
    pv_d    = pv_q;
    fb_d    = fb_q;
    abs_d   = abs_q;
    entry_o = '0;
    r       = '0;
    if ((b & ContMask) == ContPat) begin
      if (aw_q != 2'd0) begin
        pv_d = {pv_q[CpW-7:0], b[5:0]};
        aw_d = aw_q - 2'd1;
        if (aw_d == 2'd0) begin
          if (fb_q && !wide_q) begin
            entry_o.res0 = '{cp: QMark, bad: 1'b0};
            cnt          = 2'd1;
          end else if (!(strip_bom_q && abs_q && !fb_q && pv_d == BomCp)) begin
            entry_o.res0 = '{cp: pv_d, bad: 1'b0};
            cnt          = 2'd1;
          end
          fb_d = 1'b0;
        end
      end else begin
        stray = 1'b1;
      end
    end else begin
      // A non-continuation byte closes an unfinished sequence first.
      if (aw_q != 2'd0) begin
        entry_o.res0 = '{cp: QMark, bad: 1'b1};
        cnt          = 2'd1;
        aw_d         = 2'd0;
        fb_d         = 1'b0;
      end
      r = '{cp: '0, bad: 1'b0};
      if (!b[7]) begin
        r.cp = {{(CpW-8){1'b0}}, b};
      end else if ((b & Lead2Mask) == Lead2Pat) begin
        pv_d = {{(CpW-5){1'b0}}, b[4:0]};
        aw_d = 2'd1;
        fb_d = 1'b0;
      end else if ((b & Lead3Mask) == Lead3Pat) begin
        pv_d = {{(CpW-4){1'b0}}, b[3:0]};
        aw_d = 2'd2;
        fb_d = 1'b0;
      end else if ((b & Lead4Mask) == Lead4Pat) begin
        pv_d = {{(CpW-3){1'b0}}, b[2:0]};
        aw_d = 2'd3;
        fb_d = 1'b1;
      end else begin
        r.bad = 1'b1;
      end
      if (!b[7] || r.bad) begin
        if (cnt == 2'd0) entry_o.res0 = r;
        else             entry_o.res1 = r;
        cnt = cnt + 2'd1;
      end
    end

    if (in_i.last_byte) begin
      if (aw_d != 2'd0) begin
        if (cnt == 2'd0) entry_o.res0 = '{cp: QMark, bad: 1'b1};
        else             entry_o.res1 = '{cp: QMark, bad: 1'b1};
        cnt = cnt + 2'd1;
      end
      aw_d  = 2'd0;
      fb_d  = 1'b0;
      pv_d  = '0;
      abs_d = 1'b1;
    end else begin
      abs_d = abs_q && (aw_d != 2'd0) && (cnt == 2'd0) && !stray;
    end
    entry_o.two = (cnt == 2'd2);
  end

  assign push_o = accept && (cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_bom_q <= 1'b1;
      wide_q      <= 1'b1;
      aw_q        <= 2'd0;
      pv_q        <= '0;
      fb_q        <= 1'b0;
      abs_q       <= 1'b1;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgStripBom) strip_bom_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CfgWideCp)   wide_q      <= cfg_wdata_i;
      if (accept) begin
        aw_q  <= aw_d;
        pv_q  <= pv_d;
        fb_q  <= fb_d;
        abs_q <= abs_d;
      end
    end
  end

endmodule

>>> src/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue: short FIFO between the front and back parts
// Holds the results of a few bytes so each side can stall on its own.
// ----------------------------------------------------------------------------
module u8d_queue import u8d_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8d_entry_t    entry_i,
  input  logic          pop_i,
  output u8d_entry_t    head_o,
  output u8d_q_status_t status_o
);

  u8d_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

>>> src/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back: result sequencer and output register
// Sends the one or two results of each queued byte, marking the last one.
// ----------------------------------------------------------------------------
module u8d_back import u8d_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  u8d_entry_t    head_i,
  input  u8d_q_status_t status_i,
  output logic          pop_o,
  u8d_out_if.source     out_o
);

  logic     out_valid_q, sel_q, eor_q;
  u8d_res_t res_q;
  logic     load, take;

  assign load  = !out_valid_q || out_o.ready;
  assign take  = load && !status_i.empty;
  assign pop_o = take && (sel_q || !head_i.two);

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = res_q.cp;
  assign out_o.malformed  = res_q.bad;
  assign out_o.end_of_run = eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      if (load) out_valid_q <= !status_i.empty;
      if (take) sel_q       <= !pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= sel_q ? head_i.res1 : head_i.res0;
      eor_q <= pop_o;
    end
  end

endmodule

>>> test/tb_utf8_stream_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core: self-checking bench for the UTF-8 decoder core
// Streams buffers of UTF-8 bytes through the byte channel. The buffers are
// mostly well formed, with noise and cut-short sequences mixed in. A built-in
// decoder predicts each code point result, and the bench checks every result
// transaction against it over five phases of register settings, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_core;
  import u8d_pkg::*;

  localparam int NumPhases     = 5;
  localparam int PhaseBytes    = 280;   // random bytes per phase
  localparam int StallLimit    = 2000;  // cycles without any transaction
  localparam int MaxReported   = 10;
  localparam int SettleCycles  = 4;     // idle cycles before a register write
  localparam int TailCycles    = 8;     // idle cycles after the last result

  // One byte waiting to be driven, with its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_item_t;

  // One predicted result transaction.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           bad;
    logic           eor;
  } cp_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic               cfg_wdata;

  u8d_in_if  byte_ch ();
  u8d_out_if cp_ch ();

  utf8_stream_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_ch),
    .out_o       (cp_ch)
  );

  // Bytes still to be driven, and the results the decoder model still
  // expects, oldest first.
  byte_item_t byte_q[$];
  cp_result_t cp_expect_q[$];

  // Decoder model state, mirroring what the core keeps after reset.
  logic [1:0]     need_cnt   = 2'd0;
  logic [CpW-1:0] acc_cp     = '0;
  logic           lead4_open = 1'b0;
  logic           buf_start  = 1'b1;
  logic           bom_drop   = 1'b1;
  logic           wide_mode  = 1'b1;

  // Handshake bookkeeping shared by the driver, the sink and the monitor.
  // The monitor sets the taken flags at the rising edge; the drivers consume
  // them at the following falling edge, so no two processes touch them in
  // the same time step.
  bit in_busy   = 1'b0;
  bit byte_taken = 1'b0;
  bit res_taken = 1'b0;
  bit in_calm   = 1'b0;
  bit out_calm  = 1'b0;
  int in_gap    = 0;
  int out_gap   = 0;

  int stall_cycles = 0;
  int err_cnt      = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int bad_seen     = 0;
  int bytes_queued = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Idle cycles before the next transaction on one side. A calm stretch
  // draws no idling at all, so back-to-back traffic is covered as well.
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // Decoder model: consumes one accepted byte and queues the results it
  // causes. At most two results come from one byte; the final one carries
  // the end-of-run mark.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    cp_result_t res[$];
    logic       stray;
    stray = 1'b0;
    if ((b & ContMask) == ContPat) begin
      if (need_cnt != 2'd0) begin
        acc_cp   = {acc_cp[CpW-7:0], b[5:0]};
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 2'd0) begin
          // A four-byte sequence in 16-bit mode is well formed, so its
          // stand-in is not flagged. Only a three-byte U+FEFF opening the
          // buffer counts as a byte order mark.
          if (lead4_open && !wide_mode) begin
            res.insert(res.size(), cp_result_t'{cp: QMark, bad: 1'b0, eor: 1'b0});
          end else if (!(bom_drop && buf_start && !lead4_open && acc_cp == BomCp)) begin
            res.insert(res.size(), cp_result_t'{cp: acc_cp, bad: 1'b0, eor: 1'b0});
          end
          lead4_open = 1'b0;
        end
      end else begin
        // A continuation byte with nothing open is silently dropped.
        stray = 1'b1;
      end
    end else begin
      // Any other byte cuts an open sequence short before it is handled.
      if (need_cnt != 2'd0) begin
        res.insert(res.size(), cp_result_t'{cp: QMark, bad: 1'b1, eor: 1'b0});
        need_cnt   = 2'd0;
        lead4_open = 1'b0;
      end
      if (!b[7]) begin
        res.insert(res.size(), cp_result_t'{cp: CpW'(b), bad: 1'b0, eor: 1'b0});
      end else if ((b & Lead2Mask) == Lead2Pat) begin
        acc_cp     = CpW'(b[4:0]);
        need_cnt   = 2'd1;
        lead4_open = 1'b0;
      end else if ((b & Lead3Mask) == Lead3Pat) begin
        acc_cp     = CpW'(b[3:0]);
        need_cnt   = 2'd2;
        lead4_open = 1'b0;
      end else if ((b & Lead4Mask) == Lead4Pat) begin
        acc_cp     = CpW'(b[2:0]);
        need_cnt   = 2'd3;
        lead4_open = 1'b1;
      end else begin
        res.insert(res.size(), cp_result_t'{cp: '0, bad: 1'b1, eor: 1'b0});
      end
    end

    if (last) begin
      // The buffer ends inside a sequence: abandon it with a stand-in.
      if (need_cnt != 2'd0) begin
        res.insert(res.size(), cp_result_t'{cp: QMark, bad: 1'b1, eor: 1'b0});
      end
      need_cnt   = 2'd0;
      lead4_open = 1'b0;
      acc_cp     = '0;
      buf_start  = 1'b1;
    end else begin
      buf_start = buf_start && need_cnt != 2'd0 && res.size() == 0 && !stray;
    end

    if (res.size() > 0) begin
      res[res.size()-1].eor = 1'b1;
    end
    foreach (res[i]) begin
      cp_expect_q.insert(cp_expect_q.size(), res[i]);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    byte_q.insert(byte_q.size(), byte_item_t'{b: b, last: last});
    bytes_queued++;
  endtask

  function automatic logic [7:0] cont_byte(input logic [5:0] payload);
    return {2'b10, payload};
  endfunction

  // Lead byte of a sequence that awaits n continuation bytes.
  function automatic logic [7:0] lead_byte(input int n, input logic [4:0] payload);
    case (n)
      1:       return {3'b110, payload};
      2:       return {4'b1110, payload[3:0]};
      default: return {5'b11110, payload[2:0]};
    endcase
  endfunction

  // Queues one buffer of random characters. Most are well formed; the rest
  // are stray continuation bytes, invalid leads, cut-short sequences and
  // plain random bytes. A byte order mark opens some buffers.
  task automatic add_buffer();
    logic [7:0]  bytes[$];
    logic [31:0] r;
    int          nchar;
    int          kind;
    int          n;
    int          ncont;
    nchar = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) begin
      bytes.insert(bytes.size(), 8'hEF);
      bytes.insert(bytes.size(), 8'hBB);
      bytes.insert(bytes.size(), 8'hBF);
    end
    for (int i = 0; i < nchar; i++) begin
      r    = $urandom;
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        bytes.insert(bytes.size(), {1'b0, r[6:0]});
      end else if (kind < 78 || (kind >= 89 && kind < 96)) begin
        // Multi-byte sequence, complete or cut short.
        n     = (kind < 48) ? 1 : (kind < 66) ? 2 : 3;
        ncont = n;
        if (kind >= 89) begin
          n     = $urandom_range(1, 3);
          ncont = $urandom_range(0, n - 1);
        end
        bytes.insert(bytes.size(), lead_byte(n, r[4:0]));
        for (int k = 0; k < ncont; k++) begin
          bytes.insert(bytes.size(), cont_byte(r[8+6*k +: 6]));
        end
      end else if (kind < 84) begin
        bytes.insert(bytes.size(), cont_byte(r[5:0]));
      end else if (kind < 89) begin
        bytes.insert(bytes.size(), {5'b11111, r[2:0]});
      end else begin
        bytes.insert(bytes.size(), r[7:0]);
      end
    end
    foreach (bytes[i]) begin
      put_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // Registers are only written while the core is idle, so the model can
  // take the new value right away.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == CfgStripBom) begin
      bom_drop = val;
    end else begin
      wide_mode = val;
    end
  endtask

  // Waits until every queued byte is accepted and every expected result has
  // arrived, then lets a byte without results settle inside the core.
  task automatic drain();
    while (byte_q.size() != 0 || in_busy || cp_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Byte driver: presents the next byte at the falling edge once the
  // previous one was taken and its drawn gap has passed.
  always @(negedge clk_i) begin : byte_driver
    byte_item_t nxt;
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        in_busy    = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          byte_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          nxt = byte_q.pop_front();
          byte_ch.byte_in   <= nxt.b;
          byte_ch.last_byte <= nxt.last;
          byte_ch.valid     <= 1'b1;
          in_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            in_calm = !in_calm;
          end
          in_gap = draw_gap(in_calm);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: after each taken result, holds ready low for a drawn
  // number of cycles.
  always @(negedge clk_i) begin : cp_sink
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          out_calm = !out_calm;
        end
        out_gap = draw_gap(out_calm);
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        cp_ch.ready <= 1'b0;
      end else begin
        cp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: at each rising edge, feeds an accepted byte to the model first
  // and then checks an accepted result against the oldest expectation.
  always @(posedge clk_i) begin : monitor
    cp_result_t want;
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.byte_in, byte_ch.last_byte);
        byte_taken = 1'b1;
        bytes_sent++;
      end
      if (cp_ch.valid && cp_ch.ready) begin
        res_taken = 1'b1;
        results_seen++;
        if (cp_ch.malformed) begin
          bad_seen++;
        end
        if (cp_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReported) begin
            $display("%0t: unexpected result cp=%h malformed=%b end_of_run=%b", $realtime,
                     cp_ch.code_point, cp_ch.malformed, cp_ch.end_of_run);
          end
        end else begin
          want = cp_expect_q.pop_front();
          if (cp_ch.code_point !== want.cp || cp_ch.malformed !== want.bad ||
              cp_ch.end_of_run !== want.eor) begin
            err_cnt++;
            if (err_cnt <= MaxReported) begin
              $display("%0t: result mismatch cp=%h/%h malformed=%b/%b end_of_run=%b/%b",
                       $realtime, cp_ch.code_point, want.cp, cp_ch.malformed, want.bad,
                       cp_ch.end_of_run, want.eor);
            end
          end
        end
      end
      if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    bit strip_set[NumPhases];
    bit wide_set[NumPhases];
    // Phase 0 runs on the reset values; the others walk both registers
    // through every combination and end back on the reset values.
    strip_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    wide_set  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CfgStripBom;
    cfg_wdata         = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.byte_in   = 8'h00;
    byte_ch.last_byte = 1'b0;
    cp_ch.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        // Directed opening: a byte order mark at buffer start, the ASCII
        // extremes, one sequence of each length including the largest
        // four-byte value, a stray continuation, invalid leads, a sequence
        // cut short by ASCII, a lead that ends its buffer, and an overlong
        // four-byte U+FEFF that must not be taken for a byte order mark.
        put_byte(8'hEF, 1'b0); put_byte(8'hBB, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'h00, 1'b0); put_byte(8'h7F, 1'b0);
        put_byte(8'hC2, 1'b0); put_byte(8'hA9, 1'b0);
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b0); put_byte(8'hAC, 1'b0);
        put_byte(8'hF7, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b0); put_byte(8'hF8, 1'b0);
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b0); put_byte(8'h41, 1'b0);
        put_byte(8'hC3, 1'b1);
        put_byte(8'hF0, 1'b0); put_byte(8'h8F, 1'b0);
        put_byte(8'hBB, 1'b0); put_byte(8'hBF, 1'b1);
      end else begin
        drain();
        write_reg(CfgStripBom, strip_set[p]);
        write_reg(CfgWideCp, wide_set[p]);
        // Each new setting opens with a byte order mark followed by a
        // four-byte character, so both registers show their effect at once.
        put_byte(8'hEF, 1'b0); put_byte(8'hBB, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hF0, 1'b0); put_byte(8'h9F, 1'b0);
        put_byte(8'h98, 1'b0); put_byte(8'h80, 1'b1);
      end
      bytes_queued = 0;
      while (bytes_queued < PhaseBytes) begin
        add_buffer();
        // Keep the queue short so the drivers and the generator interleave.
        while (byte_q.size() > 64) begin
          @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (cp_expect_q.size() != 0) begin
      err_cnt++;
      $display("%0d expected results never arrived", cp_expect_q.size());
    end

    $display("Streamed %0d bytes under %0d register settings; %0d code points checked,",
             bytes_sent, NumPhases, results_seen);
    $display("%0d of them stand-ins for malformed input; %0d failures.", bad_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
